### hw/rtl/gkma_pkg.sv
// Shared types and constants for the gamepad key mapper with autorepeat.
// Used by gkma_ctrl, gkma_datapath and the top level; no dependencies.
package gkma_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned CountW = 18;

  // direction codes as they appear on the result
  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INITIAL_DELAY  = 2'd0;
  localparam cfg_idx_t CFG_REPEAT_INTERVAL = 2'd1;
  localparam cfg_idx_t CFG_DEAD_ZONE      = 2'd2;

  localparam logic [15:0] INITIAL_DELAY_RST   = 16'd280;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;
  localparam logic [15:0] DEAD_ZONE_RST       = 16'd7849;

  // button bit positions
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;
  localparam int unsigned BTN_START = 4;
  localparam int unsigned BTN_BACK  = 5;
  localparam int unsigned BTN_A     = 12;
  localparam int unsigned BTN_B     = 13;
  localparam int unsigned BTN_X     = 14;
  localparam int unsigned BTN_Y     = 15;

  // remainder unit runs one bit per cycle over the 16-bit dividend
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  typedef struct packed {
    logic load_in;     // capture input item
    logic eval;        // decode and update state
    logic div_step;    // one remainder iteration
    logic div_commit;  // write caught-up countdown
    logic load_out;    // move result to output register
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;    // held direction expired, catch-up required
    logic div_last;    // final remainder iteration this cycle
  } dp_sts_t;

endpackage

### hw/rtl/gkma_datapath.sv
// Datapath: config registers, input capture, direction decode, repeat countdown,
// serial remainder unit and output register. Depends on gkma_pkg.
module gkma_datapath (
  input  logic                clk,
  input  logic                rst,
  input  gkma_pkg::dp_cmd_t   cmd,
  output gkma_pkg::dp_sts_t   sts,
  input  logic                cfg_we,
  input  gkma_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                connected,
  input  logic [15:0]         buttons,
  input  logic signed [15:0]  stick_x,
  input  logic signed [15:0]  stick_y,
  input  logic [15:0]         elapsed_ms,
  output logic                pad_present,
  output logic                select_event,
  output logic                cancel_event,
  output logic                confirm_event,
  output logic [2:0]          direction_event
);
  import gkma_pkg::*;

  logic [15:0] initial_delay;
  logic [15:0] repeat_interval;
  logic [15:0] dead_zone;

  logic        in_conn;
  logic [15:0] in_btn;
  logic [15:0] in_x;
  logic [15:0] in_y;
  logic [15:0] in_el;

  logic [15:0]              prev_buttons;
  dir_t                     held_dir;
  logic signed [CountW-1:0] countdown;

  logic       res_pad, res_sel, res_can, res_conf;
  dir_t       res_dir;

  logic [15:0]        div_rem;
  logic [15:0]        div_dvd;
  logic [DivCntW-1:0] div_cnt;

  logic [16:0]              ax, ay, dz;
  dir_t                     stick_dir, new_dir;
  logic [15:0]              pressed;
  logic signed [CountW-1:0] cd_sub;
  logic [CountW-1:0]        cd_neg;
  logic                     expire;
  logic [15:0]              step;
  logic [16:0]              cand;
  logic                     cand_ge;
  logic [15:0]              rem_next;

  always_comb begin
    ax = in_x[15] ? 17'(~{1'b1, in_x} + 17'd1) : {1'b0, in_x};
    ay = in_y[15] ? 17'(~{1'b1, in_y} + 17'd1) : {1'b0, in_y};
    dz = {1'b0, dead_zone};

    if (ax < dz && ay < dz) begin
      stick_dir = DIR_NONE;
    end else if (ax >= ay) begin
      stick_dir = in_x[15] ? DIR_LEFT : DIR_RIGHT;
    end else begin
      stick_dir = in_y[15] ? DIR_DOWN : DIR_UP;
    end

    // opposite D-pad presses cancel; horizontal axis first
    priority if (in_btn[BTN_LEFT] != in_btn[BTN_RIGHT]) begin
      new_dir = in_btn[BTN_LEFT] ? DIR_LEFT : DIR_RIGHT;
    end else if (in_btn[BTN_UP] != in_btn[BTN_DOWN]) begin
      new_dir = in_btn[BTN_UP] ? DIR_UP : DIR_DOWN;
    end else begin
      new_dir = stick_dir;
    end

    pressed = in_btn & ~prev_buttons;

    cd_sub = countdown - $signed({2'b00, in_el});
    expire = cd_sub[CountW-1] || (cd_sub == '0);
    cd_neg = CountW'(-cd_sub);

    step = (repeat_interval == 16'd0) ? 16'd1 : repeat_interval;

    // restoring remainder step
    cand     = {div_rem, div_dvd[15]};
    cand_ge  = cand >= {1'b0, step};
    rem_next = cand_ge ? 16'(cand - {1'b0, step}) : cand[15:0];
  end

  assign sts.need_div = in_conn && (new_dir != DIR_NONE) && (new_dir == held_dir) && expire;
  assign sts.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay   <= INITIAL_DELAY_RST;
      repeat_interval <= REPEAT_INTERVAL_RST;
      dead_zone       <= DEAD_ZONE_RST;
      prev_buttons    <= '0;
      held_dir        <= DIR_NONE;
      countdown       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INITIAL_DELAY:   initial_delay   <= cfg_data;
          CFG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
          CFG_DEAD_ZONE:       dead_zone       <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (!in_conn) begin
          prev_buttons <= '0;
          held_dir     <= DIR_NONE;
          countdown    <= '0;
        end else begin
          prev_buttons <= in_btn;
          if (new_dir == DIR_NONE) begin
            held_dir  <= DIR_NONE;
            countdown <= '0;
          end else if (new_dir != held_dir) begin
            held_dir  <= new_dir;
            countdown <= $signed({2'b00, initial_delay});
          end else if (!expire) begin
            countdown <= cd_sub;
          end
        end
      end
      // caught-up count is the first positive value: step minus remainder
      if (cmd.div_commit) begin
        countdown <= $signed({2'b00, 16'(step - div_rem)});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_conn <= connected;
      in_btn  <= buttons;
      in_x    <= stick_x;
      in_y    <= stick_y;
      in_el   <= elapsed_ms;
    end
    if (cmd.eval) begin
      res_pad  <= in_conn;
      res_sel  <= in_conn && (pressed[BTN_A] || pressed[BTN_X]);
      res_can  <= in_conn && (pressed[BTN_BACK] || pressed[BTN_B]);
      res_conf <= in_conn && (pressed[BTN_START] || pressed[BTN_Y]);
      if (!in_conn) begin
        res_dir <= DIR_NONE;
      end else if (new_dir != held_dir || sts.need_div) begin
        res_dir <= new_dir;
      end else begin
        res_dir <= DIR_NONE;
      end
      div_rem <= '0;
      div_dvd <= cd_neg[15:0];
      div_cnt <= DivCntW'(DivSteps - 1);
    end else if (cmd.div_step) begin
      div_rem <= rem_next;
      div_dvd <= {div_dvd[14:0], 1'b0};
      div_cnt <= div_cnt - DivCntW'(1);
    end
    if (cmd.load_out) begin
      pad_present     <= res_pad;
      select_event    <= res_sel;
      cancel_event    <= res_can;
      confirm_event   <= res_conf;
      direction_event <= res_dir;
    end
  end

endmodule

### hw/rtl/gkma_ctrl.sv
// Controller: sequences capture, decode, remainder iterations and output load.
// Owns both handshakes. Depends on gkma_pkg.
module gkma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gkma_pkg::dp_cmd_t cmd,
  input  gkma_pkg::dp_sts_t sts
);
  import gkma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state == S_IDLE) && in_valid;
    cmd.eval       = (state == S_EVAL);
    cmd.div_step   = (state == S_DIV);
    cmd.div_commit = (state == S_FIX);
    cmd.load_out   = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving this cycle
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          state <= sts.need_div ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (sts.div_last) state <= S_FIX;
        end
        S_FIX: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/gamepad_key_mapper_autorepeat_core.sv
// Gamepad key mapper with dead zone and typematic autorepeat, top level.
// Instantiates gkma_ctrl and gkma_datapath; depends on gkma_pkg.
//
// Usage: one gamepad poll enters per item on the input channel (in_valid /
// in_stall) and exactly one result leaves on the output channel (out_valid /
// out_stall). An item is taken when valid is high and stall is low.
// Config registers (0 initial delay, 1 repeat interval, 2 dead zone) are
// written through cfg_valid / cfg_ready / cfg_index / cfg_data; the user must
// write them only while idle; the block does not enforce it. cfg_ready is
// always high, writes to unused indexes are dropped. An item goes from accept
// to the output register load; when a held direction expires, the catch-up
// count is formed by a one-bit-per-cycle remainder unit (16 iterations plus
// one write-back state). The result is valid the cycle after that load; the
// next item is accepted as soon as the controller is back to idle, even
// while the previous result still waits in the output register.
// A stalled result holds its payload; the controller then waits in its
// final state with in_stall high until the output register frees up.
// Reset (rst, synchronous) restores the register defaults, clears the held
// direction, countdown and previous buttons, and empties the output.
module gamepad_key_mapper_autorepeat_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                connected,
  input  logic [15:0]         buttons,
  input  logic signed [15:0]  stick_x,
  input  logic signed [15:0]  stick_y,
  input  logic [15:0]         elapsed_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                pad_present,
  output logic                select_event,
  output logic                cancel_event,
  output logic                confirm_event,
  output logic [2:0]          direction_event,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  gkma_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_data
);
  import gkma_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  gkma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  gkma_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .connected       (connected),
    .buttons         (buttons),
    .stick_x         (stick_x),
    .stick_y         (stick_y),
    .elapsed_ms      (elapsed_ms),
    .pad_present     (pad_present),
    .select_event    (select_event),
    .cancel_event    (cancel_event),
    .confirm_event   (confirm_event),
    .direction_event (direction_event)
  );

  // an accepted item closes the input side in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous item still in work");

  // a result only becomes valid through an output register load
  a_out_after_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result shown without output load");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction_event <= 3'(DIR_DOWN)))
    else $error("direction code out of range");

  // a disconnected poll reports no events
  a_no_pad_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pad_present) |->
      (!select_event && !cancel_event && !confirm_event &&
       direction_event == 3'(DIR_NONE)))
    else $error("event reported without a pad");

endmodule
